// ===== rtl/seeded_wavefront_distance_map_defines.svh =====
// Assertion helpers for the seeded wavefront distance map.
`ifndef SEEDED_WAVEFRONT_DISTANCE_MAP_DEFINES_SVH
`define SEEDED_WAVEFRONT_DISTANCE_MAP_DEFINES_SVH

`ifndef SYNTHESIS
`define SWDM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define SWDM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define SWDM_ASSERT(lbl, prop, msg)
`define SWDM_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/swdm_pkg.sv =====
`timescale 1ns / 1ps
package swdm_pkg;

   localparam int MAX_DIM     = 128;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int MAP_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int MAP_AW      = $clog2(MAP_DEPTH);
   localparam int MAX_SEEDS   = 256;
   localparam int SEED_W      = $clog2(MAX_SEEDS);
   localparam int SCNT_W      = SEED_W + 1;
   localparam int QUEUE_DEPTH = 32768;
   localparam int Q_AW        = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = Q_AW + 1;
   localparam int DIST_W      = 16;
   localparam int CFG_W       = 8;

   localparam logic [DIST_W-1:0] UNREACHED = 16'hFFFF;
   localparam logic [DIST_W-1:0] DIST_SAT  = 16'hFFFE;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef enum logic [1:0] {
      FN_CLEAR = 2'd0,
      FN_SEED  = 2'd1,
      FN_PROP  = 2'd2,
      FN_READ  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      func_type           func;
      logic signed [15:0] row;
      logic signed [15:0] col;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        reached;
      logic [15:0] sq_distance;
      logic [7:0]  seed_index;
   } rsp_type;

   typedef struct packed {
      logic [SEED_W-1:0] label;
      logic [DIST_W-1:0] dval;
   } map_word_type;

   typedef struct packed {
      logic [DIM_W-1:0]  r;
      logic [DIM_W-1:0]  c;
      logic [SEED_W-1:0] seed;
      logic [DIST_W-1:0] d;
   } queue_word_type;

   typedef struct packed {
      logic [DIM_W-1:0] r;
      logic [DIM_W-1:0] c;
   } seed_word_type;

   // Neighbor visit order as (drow, dcol).
   localparam logic signed [1:0] NBR_DR [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                                2'sd0, -2'sd1, -2'sd1, -2'sd1};
   localparam logic signed [1:0] NBR_DC [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                                -2'sd1, -2'sd1, 2'sd0, 2'sd1};

   // Clamp a size register to 1..MAX_DIM.
   function automatic logic [DIM_W:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W:0] res;
      if (v == '0) res = (DIM_W+1)'(1);
      else if (32'(v) > MAX_DIM) res = (DIM_W+1)'(MAX_DIM);
      else res = (DIM_W+1)'(v);
      return res;
   endfunction

endpackage

// ===== rtl/swdm_ram.sv =====
`timescale 1ns / 1ps
module swdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/seeded_wavefront_distance_map.sv =====
`timescale 1ns / 1ps
// Seeded wavefront distance map. Issue a command with start while busy is low.
// Exactly one result item comes back on rsp_item, marked by a one-cycle
// rsp_valid strobe that the receiver cannot hold off. Clear sweeps the
// 16384-entry map one entry a cycle, so busy stays high for the whole sweep
// and the result strobes in the cycle after it. The same sweep runs after
// reset, with busy high and no result. An add seed or read inside the image
// keeps busy high through its map read state and its write or output state,
// and its result strobes as busy falls. An add seed or read outside the
// image, or an add to a full seed table, strobes in the next cycle without
// raising busy. Propagate drains the work queue. Each popped pixel passes
// S_P_POP, S_P_QW and S_P_MW, then each in-image neighbor S_P_NB, S_P_SQ and
// S_P_CMP, and each neighbor off the image S_P_NB alone. A pixel superseded
// by a closer seed skips the neighbor states. S_P_POP finishes once it finds
// the queue empty, and the result strobes in the cycle after that. The map
// memory's single read port sets this pace. Write the size registers only while idle.
module seeded_wavefront_distance_map (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  swdm_pkg::req_type         req_item,
   output logic                      rsp_valid,
   output swdm_pkg::rsp_type         rsp_item,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [swdm_pkg::CFG_W-1:0] csr_wdata
);
   import swdm_pkg::*;

   `include "seeded_wavefront_distance_map_defines.svh"

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SEED_RD, S_SEED_WR, S_READ_RD, S_READ_OUT,
      S_P_POP, S_P_QW, S_P_MW, S_P_NB, S_P_SQ, S_P_CMP
   } state_type;

   state_type            state_ff;
   req_type              cmd_ff;
   logic [MAP_AW-1:0]    sweep_ff;
   logic                 clr_rsp_ff;
   logic [CFG_W-1:0]     rows_ff, cols_ff;
   logic [SCNT_W-1:0]    seed_count_ff;
   logic [Q_AW-1:0]      head_ff, tail_ff;
   logic [FILL_W-1:0]    fill_ff;
   queue_word_type       item_ff;
   seed_word_type        seed_pos_ff;
   logic [2:0]           k_ff;
   logic [DIM_W-1:0]     nbr_r_ff, nbr_c_ff;
   logic signed [DIM_W+1:0] dx_ff, dy_ff;
   logic [DIST_W-1:0]    d_ff;
   status_type           prop_status_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // memory ports
   logic                 map_we;
   logic [MAP_AW-1:0]    map_waddr, map_raddr;
   map_word_type         map_wdata, map_rdata;
   logic                 q_we;
   queue_word_type       q_wdata, q_rdata;
   logic                 seed_we;
   seed_word_type        seed_wdata, seed_rdata;
   logic [SEED_W-1:0]    seed_raddr;

   // decode
   logic [DIM_W:0]       rows_eff, cols_eff;
   logic                 req_inside;
   logic [MAP_AW-1:0]    cmd_idx;
   logic                 q_full, fresh, better;
   logic signed [DIM_W+1:0] nr, nc;
   logic                 nbr_ok;
   logic signed [2*DIM_W+4:0] dx_w, dy_w;
   logic [2*DIM_W+4:0]   sq;
   logic [DIST_W-1:0]    d_sat;

   assign rows_eff   = eff_dim(rows_ff);
   assign cols_eff   = eff_dim(cols_ff);
   assign req_inside = !req_item.row[15] && !req_item.col[15]
                       && (req_item.row[14:0] < 15'(rows_eff))
                       && (req_item.col[14:0] < 15'(cols_eff));
   assign cmd_idx    = {cmd_ff.row[DIM_W-1:0], cmd_ff.col[DIM_W-1:0]};
   assign q_full     = fill_ff >= FILL_W'(QUEUE_DEPTH);
   assign fresh      = map_rdata.dval != '0;
   assign better     = map_rdata.dval > d_ff;

   // neighbor coordinates and the in-image check
   assign nr = $signed({2'b00, item_ff.r}) + (DIM_W+2)'(NBR_DR[k_ff]);
   assign nc = $signed({2'b00, item_ff.c}) + (DIM_W+2)'(NBR_DC[k_ff]);
   assign nbr_ok = !nr[DIM_W+1] && !nc[DIM_W+1]
                   && (nr[DIM_W:0] < rows_eff) && (nc[DIM_W:0] < cols_eff);

   // squared distance; widen the offsets before squaring
   assign dx_w  = (2*DIM_W+5)'(dx_ff);
   assign dy_w  = (2*DIM_W+5)'(dy_ff);
   assign sq    = $unsigned(dx_w * dx_w) + $unsigned(dy_w * dy_w);
   assign d_sat = (sq > (2*DIM_W+5)'(DIST_SAT)) ? DIST_SAT : DIST_W'(sq);

   // memory control
   always_comb begin
      map_we     = 1'b0;
      map_waddr  = {nbr_r_ff, nbr_c_ff};
      map_wdata  = '{label: item_ff.seed, dval: d_ff};
      map_raddr  = '0;
      q_we       = 1'b0;
      q_wdata    = '{r: nbr_r_ff, c: nbr_c_ff, seed: item_ff.seed, d: d_ff};
      seed_we    = 1'b0;
      seed_wdata = '{r: cmd_ff.row[DIM_W-1:0], c: cmd_ff.col[DIM_W-1:0]};
      seed_raddr = q_rdata.seed;
      unique case (state_ff)
         S_INIT: begin
            map_we    = 1'b1;
            map_waddr = sweep_ff;
            map_wdata = '{label: '0, dval: UNREACHED};
         end
         S_SEED_RD, S_READ_RD: map_raddr = cmd_idx;
         S_SEED_WR: begin
            // a seed on a distance-zero pixel is counted but not queued
            seed_we   = !(fresh && q_full);
            map_we    = fresh && !q_full;
            map_waddr = cmd_idx;
            map_wdata = '{label: seed_count_ff[SEED_W-1:0], dval: '0};
            q_we      = fresh && !q_full;
            q_wdata   = '{r: cmd_ff.row[DIM_W-1:0], c: cmd_ff.col[DIM_W-1:0],
                          seed: seed_count_ff[SEED_W-1:0], d: '0};
         end
         S_P_QW:  map_raddr = {q_rdata.r, q_rdata.c};
         S_P_SQ:  map_raddr = {nbr_r_ff, nbr_c_ff};
         S_P_CMP: begin
            map_we = better && !q_full;
            q_we   = better && !q_full;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff      <= S_INIT;
         sweep_ff      <= '0;
         clr_rsp_ff    <= 1'b0;
         rows_ff       <= CFG_W'(MAX_DIM);
         cols_ff       <= CFG_W'(MAX_DIM);
         seed_count_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         k_ff          <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS: rows_ff <= csr_wdata;
               CSR_COLS: cols_ff <= csr_wdata;
            endcase
         end
         unique case (state_ff)
            S_INIT: begin
               // sweep the map back to unreached
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == '1) begin
                  state_ff <= S_IDLE;
                  if (clr_rsp_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{status: ST_OK, default: '0};
                  end
               end
            end
            S_IDLE: begin
               if (start) begin
                  cmd_ff <= req_item;
                  unique case (req_item.func)
                     FN_CLEAR: begin
                        sweep_ff      <= '0;
                        clr_rsp_ff    <= 1'b1;
                        seed_count_ff <= '0;
                        head_ff       <= '0;
                        tail_ff       <= '0;
                        fill_ff       <= '0;
                        state_ff      <= S_INIT;
                     end
                     FN_SEED: begin
                        priority if (!req_inside) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff       <= '{status: ST_RANGE, default: '0};
                        end else if (seed_count_ff >= SCNT_W'(MAX_SEEDS)) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff       <= '{status: ST_FULL, default: '0};
                        end else begin
                           rsp_ff   <= '{status: ST_OK, default: '0};
                           state_ff <= S_SEED_RD;
                        end
                     end
                     FN_PROP: begin
                        rsp_ff         <= '{status: ST_OK, default: '0};
                        prop_status_ff <= ST_OK;
                        state_ff       <= S_P_POP;
                     end
                     FN_READ: begin
                        if (!req_inside) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff       <= '{status: ST_RANGE, default: '0};
                        end else begin
                           rsp_ff   <= '{status: ST_OK, default: '0};
                           state_ff <= S_READ_RD;
                        end
                     end
                  endcase
               end
            end
            S_SEED_RD: state_ff <= S_SEED_WR;
            S_SEED_WR: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
               if (fresh && q_full) begin
                  rsp_ff.status <= ST_OVERFLOW;
               end else begin
                  rsp_ff.seed_index <= seed_count_ff[SEED_W-1:0];
                  seed_count_ff     <= seed_count_ff + 1'b1;
                  if (fresh) begin
                     tail_ff <= tail_ff + 1'b1;
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
            end
            S_READ_RD: state_ff <= S_READ_OUT;
            S_READ_OUT: begin
               rsp_valid_ff        <= 1'b1;
               rsp_ff.sq_distance  <= map_rdata.dval;
               rsp_ff.reached      <= map_rdata.dval != UNREACHED;
               rsp_ff.seed_index   <= (map_rdata.dval != UNREACHED) ? map_rdata.label : '0;
               state_ff            <= S_IDLE;
            end
            S_P_POP: begin
               // pop the head item, or finish once the queue is empty
               if (fill_ff == '0) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_ff.status <= prop_status_ff;
                  state_ff      <= S_IDLE;
               end else begin
                  head_ff  <= head_ff + 1'b1;
                  fill_ff  <= fill_ff - 1'b1;
                  state_ff <= S_P_QW;
               end
            end
            S_P_QW: begin
               item_ff  <= q_rdata;
               state_ff <= S_P_MW;
            end
            S_P_MW: begin
               seed_pos_ff <= seed_rdata;
               k_ff        <= '0;
               // drop stale items superseded by a closer seed
               state_ff    <= (map_rdata.dval < item_ff.d) ? S_P_POP : S_P_NB;
            end
            S_P_NB: begin
               nbr_r_ff <= nr[DIM_W-1:0];
               nbr_c_ff <= nc[DIM_W-1:0];
               dx_ff    <= nc - $signed({2'b00, seed_pos_ff.c});
               dy_ff    <= nr - $signed({2'b00, seed_pos_ff.r});
               if (nbr_ok) begin
                  state_ff <= S_P_SQ;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= (k_ff == 3'd7) ? S_P_POP : S_P_NB;
               end
            end
            S_P_SQ: begin
               d_ff     <= d_sat;
               state_ff <= S_P_CMP;
            end
            S_P_CMP: begin
               if (better) begin
                  if (q_full) begin
                     prop_status_ff <= ST_OVERFLOW;
                  end else begin
                     tail_ff <= tail_ff + 1'b1;
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= (k_ff == 3'd7) ? S_P_POP : S_P_NB;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   swdm_ram #(.WIDTH($bits(map_word_type)), .DEPTH(MAP_DEPTH)) u_map (
      .clock(clock), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
      .raddr(map_raddr), .rdata(map_rdata)
   );

   swdm_ram #(.WIDTH($bits(seed_word_type)), .DEPTH(MAX_SEEDS)) u_seeds (
      .clock(clock), .we(seed_we), .waddr(seed_count_ff[SEED_W-1:0]),
      .wdata(seed_wdata), .raddr(seed_raddr), .rdata(seed_rdata)
   );

   swdm_ram #(.WIDTH($bits(queue_word_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .we(q_we), .waddr(tail_ff), .wdata(q_wdata),
      .raddr(head_ff), .rdata(q_rdata)
   );

   `SWDM_ASSERT(a_fill_bound, fill_ff <= FILL_W'(QUEUE_DEPTH), "queue fill beyond depth")
   `SWDM_ASSERT(a_empty_ptrs, (fill_ff != '0) || (head_ff == tail_ff), "empty queue, pointers differ")
   `SWDM_ASSERT_NEXT(a_accept_busy, start && !busy && req_item.func != FN_READ && req_item.func != FN_SEED, busy, "no busy after command")
   `SWDM_ASSERT(a_rsp_idle, !rsp_valid || !busy, "result strobe while busy")

endmodule

// ===== sim/seeded_wavefront_distance_map_tb.sv =====
`timescale 1ns / 1ps
module seeded_wavefront_distance_map_tb;
   import swdm_pkg::*;

   localparam int STALL_LIMIT = 2000000;
   localparam int MAP_STRIDE  = 128;

   // One pending wavefront entry of the shadow map.
   typedef struct {
      int r;
      int c;
      int seed;
      int d;
   } wave_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   seeded_wavefront_distance_map dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the block's state.
   logic [15:0] shadow_dist  [MAP_STRIDE*MAP_STRIDE];
   logic [7:0]  shadow_owner [MAP_STRIDE*MAP_STRIDE];
   int          seed_r [256];
   int          seed_c [256];
   int          seed_total;
   wave_entry_type wavefront [$];
   int          rows_reg = 128;
   int          cols_reg = 128;
   int          step_dr [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
   int          step_dc [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

   rsp_type pending_rsp [$];
   int      idle_pct = 0;
   int      fail_count = 0;
   int      items_sent = 0;
   int      rsp_checked = 0;
   int      seeds_seen = 0;
   int      reads_seen = 0;

   function automatic int clamp_dim(int v);
      if (v < 1) return 1;
      if (v > MAP_STRIDE) return MAP_STRIDE;
      return v;
   endfunction

   function void clear_shadow();
      for (int i = 0; i < MAP_STRIDE*MAP_STRIDE; i++) shadow_dist[i] = 16'hFFFF;
      seed_total = 0;
      wavefront.delete();
   endfunction

   // Drain the wavefront the way the block does; report overflow if any push fails.
   function status_type run_wavefront();
      status_type     st;
      wave_entry_type w;
      wave_entry_type nw;
      int             rows, cols, nr, nc, dx, dy, d, idx;
      st = ST_OK;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      while (wavefront.size() > 0) begin
         w = wavefront.pop_front();
         if (shadow_dist[w.r*MAP_STRIDE + w.c] < w.d) continue;
         for (int k = 0; k < 8; k++) begin
            nr = w.r + step_dr[k];
            nc = w.c + step_dc[k];
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            dx = nc - seed_c[w.seed];
            dy = nr - seed_r[w.seed];
            d = dx*dx + dy*dy;
            if (d > 65534) d = 65534;
            idx = nr*MAP_STRIDE + nc;
            if (shadow_dist[idx] <= d) continue;
            if (wavefront.size() >= QUEUE_DEPTH) begin
               st = ST_OVERFLOW;
               continue;
            end
            nw.r = nr;
            nw.c = nc;
            nw.seed = w.seed;
            nw.d = d;
            wavefront.insert(wavefront.size(), nw);
            shadow_dist[idx] = d[15:0];
            shadow_owner[idx] = w.seed[7:0];
         end
      end
      return st;
   endfunction

   function rsp_type predict_map_result(req_type rq);
      rsp_type        rs;
      int             r, c, idx;
      bit             in_image;
      bit             fresh;
      wave_entry_type nw;
      rs = '0;
      r = rq.row;
      c = rq.col;
      in_image = r >= 0 && c >= 0 && r < clamp_dim(rows_reg) && c < clamp_dim(cols_reg);
      idx = r*MAP_STRIDE + c;
      case (rq.func)
         FN_CLEAR: clear_shadow();
         FN_SEED: begin
            if (!in_image) rs.status = ST_RANGE;
            else if (seed_total >= MAX_SEEDS) rs.status = ST_FULL;
            else begin
               fresh = shadow_dist[idx] != 16'd0;
               if (fresh && wavefront.size() >= QUEUE_DEPTH) rs.status = ST_OVERFLOW;
               else begin
                  if (fresh) begin
                     nw.r = r;
                     nw.c = c;
                     nw.seed = seed_total;
                     nw.d = 0;
                     wavefront.insert(wavefront.size(), nw);
                     shadow_dist[idx] = 16'd0;
                     shadow_owner[idx] = seed_total[7:0];
                  end
                  seed_r[seed_total] = r;
                  seed_c[seed_total] = c;
                  rs.seed_index = seed_total[7:0];
                  seed_total++;
               end
            end
         end
         FN_PROP: rs.status = run_wavefront();
         default: begin
            if (!in_image) rs.status = ST_RANGE;
            else begin
               rs.sq_distance = shadow_dist[idx];
               if (shadow_dist[idx] != 16'hFFFF) begin
                  rs.reached = 1'b1;
                  rs.seed_index = shadow_owner[idx];
               end
            end
         end
      endcase
      return rs;
   endfunction

   // Send one command item; hold start high across back-to-back items.
   task automatic send_cmd(func_type f, int r, int c);
      req_type rq;
      int      gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rq.func = f;
      rq.row = r[15:0];
      rq.col = c[15:0];
      start <= 1'b1;
      req_item <= rq;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      // Accepted at this edge: predict now, before any later item changes state.
      pending_rsp.insert(pending_rsp.size(), predict_map_result(rq));
      items_sent++;
      if (f == FN_SEED) seeds_seen++;
      if (f == FN_READ) reads_seen++;
   endtask

   // Drop start and hold until every expected result has come back.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() > 0 || busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Write both size registers; only called once the block is idle.
   task automatic set_size(int rows, int cols);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows[7:0];
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= cols[7:0];
      @(posedge clock);
      csr_we <= 1'b0;
      rows_reg = rows & 255;
      cols_reg = cols & 255;
   endtask

   // Compare every result strobe with the oldest prediction.
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result status=%0d", $realtime, rsp_item.status);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            rsp_checked++;
            if (rsp_item.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $realtime, want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.reached !== want.reached) begin
               $display("%0t: reached exp %0d got %0d", $realtime, want.reached,
                        rsp_item.reached);
               fail_count++;
            end
            if (rsp_item.sq_distance !== want.sq_distance) begin
               $display("%0t: sq_distance exp %0d got %0d", $realtime, want.sq_distance,
                        rsp_item.sq_distance);
               fail_count++;
            end
            if (rsp_item.seed_index !== want.seed_index) begin
               $display("%0t: seed_index exp %0d got %0d", $realtime, want.seed_index,
                        rsp_item.seed_index);
               fail_count++;
            end
         end
      end
   end

   // Count cycles without any handshake; the clear sweep after reset is covered.
   always @(negedge clock) begin
      int stall;
      if ((start && !busy) || rsp_valid) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, stall);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Fresh map: nothing reached, out-of-range read, empty propagate.
   task automatic test_reset_state();
      send_cmd(FN_READ, 0, 0);
      send_cmd(FN_READ, 127, 127);
      send_cmd(FN_READ, 128, 0);
      send_cmd(FN_PROP, 0, 0);
      send_cmd(FN_CLEAR, 0, 0);
   endtask

   // Narrow images at the largest size, edge seeds, duplicates and bad coordinates.
   task automatic test_extremes();
      set_size(128, 2);
      send_cmd(FN_CLEAR, 0, 0);
      send_cmd(FN_SEED, 0, 0);
      send_cmd(FN_SEED, 127, 1);
      send_cmd(FN_SEED, 0, 0);
      send_cmd(FN_SEED, 128, 0);
      send_cmd(FN_SEED, -1, 0);
      send_cmd(FN_SEED, -32768, 32767);
      send_cmd(FN_PROP, 0, 0);
      send_cmd(FN_READ, 127, 0);
      send_cmd(FN_READ, 64, 1);
      send_cmd(FN_READ, 0, 0);
      send_cmd(FN_READ, 0, 2);
      send_cmd(FN_READ, 32767, -32768);
      // Zero and oversize registers clamp to 1 and the full size.
      set_size(255, 0);
      send_cmd(FN_CLEAR, 0, 0);
      send_cmd(FN_SEED, 5, 0);
      send_cmd(FN_PROP, 0, 0);
      send_cmd(FN_READ, 127, 0);
      send_cmd(FN_READ, 0, 1);
   endtask

   // Fill the seed table, then one more add must bounce.
   task automatic test_seed_table_full();
      set_size(16, 16);
      send_cmd(FN_CLEAR, 0, 0);
      for (int i = 0; i <= MAX_SEEDS; i++)
         send_cmd(FN_SEED, $urandom_range(15), $urandom_range(15));
      send_cmd(FN_PROP, 0, 0);
      send_cmd(FN_READ, 7, 7);
      send_cmd(FN_READ, 15, 0);
   endtask

   // Shrink the image between seeding and propagation, then grow it back.
   task automatic test_size_change();
      set_size(12, 12);
      send_cmd(FN_CLEAR, 0, 0);
      send_cmd(FN_SEED, 3, 3);
      send_cmd(FN_SEED, 10, 9);
      set_size(12, 5);
      send_cmd(FN_PROP, 0, 0);
      send_cmd(FN_READ, 3, 4);
      send_cmd(FN_READ, 11, 4);
      set_size(12, 12);
      send_cmd(FN_READ, 3, 10);
      send_cmd(FN_READ, 10, 9);
   endtask

   // Mostly clear/seed/propagate/read sequences with random content, some noise.
   task automatic test_random_traffic(int pct, int budget);
      int rows, cols, n, target;
      idle_pct = pct;
      target = items_sent + budget;
      while (items_sent < target) begin
         // Pause here until idle: also lets sizes change between sequences.
         rows = $urandom_range(1, 20);
         cols = $urandom_range(1, 20);
         case ($urandom_range(7))
            0: rows = 128;
            1: cols = 128;
            2: rows = 0;
            3: cols = 255;
            default: ;
         endcase
         set_size(rows, cols);
         rows = clamp_dim(rows);
         cols = clamp_dim(cols);
         if ($urandom_range(3) != 0) begin
            send_cmd(FN_CLEAR, 0, 0);
            n = $urandom_range(1, 5);
            repeat (n) begin
               if ($urandom_range(7) == 0) send_cmd(FN_SEED, $urandom, $urandom);
               else send_cmd(FN_SEED, $urandom_range(rows-1), $urandom_range(cols-1));
            end
            send_cmd(FN_PROP, 0, 0);
            n = $urandom_range(3, 6);
            repeat (n) send_cmd(FN_READ, $urandom_range(rows-1), $urandom_range(cols-1));
         end else begin
            repeat (5) begin
               func_type f;
               f = func_type'($urandom_range(3));
               send_cmd(f, $urandom, $urandom);
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      clear_shadow();
      test_reset_state();
      test_extremes();
      test_seed_table_full();
      test_size_change();
      test_random_traffic(10, 35);
      test_random_traffic(64, 35);
      test_random_traffic(0, 35);
      drain();
      repeat (20) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0t: %0d results never arrived", $realtime, pending_rsp.size());
         fail_count++;
      end
      $display("Covered %0d commands (%0d seed adds, %0d reads), %0d results compared,",
               items_sent, seeds_seen, reads_seen, rsp_checked);
      $display("across clamped, narrow, full-table and resized-image settings.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== seeded_wavefront_distance_map.f =====
+incdir+rtl
rtl/swdm_pkg.sv
rtl/swdm_ram.sv
rtl/seeded_wavefront_distance_map.sv
sim/seeded_wavefront_distance_map_tb.sv
